// ===== sv/neighbor_liveness_table_defines.svh =====
// Assertion macros for the neighbour liveness table.
`ifndef NEIGHBOR_LIVENESS_TABLE_DEFINES_SVH
`define NEIGHBOR_LIVENESS_TABLE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define NLT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("neighbor_liveness_table: check failed");

// Check a consequent in the cycle after its antecedent.
`define NLT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("neighbor_liveness_table: check failed");

`endif

// ===== sv/nlt_pkg.sv =====
// Package for the neighbour liveness table: widths, codes, types and entry update functions.
package nlt_pkg;

  // Table size default and field widths
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned NADDR_W           = 8;
  localparam int unsigned MISS_W            = 7;
  localparam int unsigned RL_W              = 5;
  localparam int unsigned SLOT_W            = 4;
  localparam int unsigned ECNT_W            = 5;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_RETRY_LIMIT = 1'b0;
  localparam logic [RL_W-1:0] RETRY_LIMIT_RESET = 5'd3;

  // Item kinds
  typedef enum logic [1:0] {
    ACT_BEACON = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [NADDR_W-1:0] addr;
    logic [MISS_W-1:0]  miss;
    logic               mark;
  } entry_t;

  // One result item
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot_index;
    logic [MISS_W-1:0] miss_count;
    logic              suspect;
    logic [ECNT_W-1:0] entry_count;
    logic              dropped_full;
  } res_t;

  // Aging step: mark a fresh entry, else count a miss while the miss count divided by four is below the limit
  function automatic entry_t age_entry(entry_t e, logic [RL_W-1:0] limit);
    entry_t r;
    r = e;
    if (e.mark) begin
      if (e.miss[MISS_W-1:2] < limit) begin
        r.miss = e.miss + MISS_W'(1);
      end
    end else begin
      r.mark = 1'b1;
    end
    return r;
  endfunction

  // Beacon refresh: clear the mark and take one miss off the counter
  function automatic entry_t refresh_entry(entry_t e);
    entry_t r;
    r = e;
    r.mark = 1'b0;
    if (e.miss != '0) begin
      r.miss = e.miss - MISS_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/nlt_in_if.sv =====
// Input item channel: valid/ready handshake with action and address.
interface nlt_in_if import nlt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [NADDR_W-1:0] address;

  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

// ===== sv/nlt_out_if.sv =====
// Result channel: valid/ready handshake with the lookup and status fields.
interface nlt_out_if import nlt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot_index;
  logic [MISS_W-1:0] miss_count;
  logic              suspect;
  logic [ECNT_W-1:0] entry_count;
  logic              dropped_full;

  modport source (output valid, hit, slot_index, miss_count, suspect, entry_count,
                  dropped_full, input ready);
  modport sink   (input valid, hit, slot_index, miss_count, suspect, entry_count,
                  dropped_full, output ready);
endinterface

// ===== sv/nlt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module nlt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/nlt_seq.sv =====
// Sequencer for the neighbour table: scans the entry RAM, updates entries and forms results.
module nlt_seq import nlt_pkg::*; #(
  parameter int unsigned ENTRIES = TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [RL_W-1:0]  retry_limit,
  nlt_in_if.sink           item,
  nlt_out_if.source        result,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output entry_t           ram_wdata,
  output logic             ram_re,
  output logic [IDX_W-1:0] ram_raddr,
  input  entry_t           ram_rdata
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  state_t             state, state_next;
  act_t               act_q;
  logic [NADDR_W-1:0] addr_q;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]   count, count_next;
  res_t               res, res_next;
  logic               out_valid;
  res_t               out_res;
  logic               load_out;

  act_t               cur_act;
  logic [NADDR_W-1:0] cur_addr;
  logic [IDX_W-1:0]   idx_inc;
  logic [CNT_W-1:0]   count_inc;
  logic               last;
  logic               full;
  logic               match;
  logic               accept;
  res_t               res_zero;

  assign accept    = item.valid && item.ready;
  assign cur_act   = (state == ST_IDLE) ? act_t'(item.action) : act_q;
  assign cur_addr  = (state == ST_IDLE) ? item.address : addr_q;
  assign idx_inc   = idx + IDX_W'(1);
  assign count_inc = count + CNT_W'(1);
  assign last      = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign full      = count == CNT_W'(ENTRIES);
  assign match     = ram_rdata.addr == cur_addr;

  // Result with no entry attached
  always_comb begin
    res_zero             = '0;
    res_zero.entry_count = ECNT_W'(count);
  end

  // Next state, RAM accesses and result
  always_comb begin
    logic tail;
    entry_t upd;
    tail       = 1'b0;
    upd        = refresh_entry(ram_rdata);
    state_next = state;
    idx_next   = idx;
    count_next = count;
    res_next   = res;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = age_entry(ram_rdata, retry_limit);
    ram_re     = 1'b0;
    ram_raddr  = idx;
    load_out   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cur_act == ACT_NONE || count == '0) begin
            tail       = 1'b1;
            state_next = ST_EMIT;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = '0;
            idx_next   = '0;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        unique case (cur_act)
          ACT_TICK: begin
            ram_we = 1'b1;
            if (last) begin
              res_next   = res_zero;
              state_next = ST_EMIT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = idx_inc;
              idx_next  = idx_inc;
            end
          end
          ACT_BEACON, ACT_LOOKUP: begin
            if (match) begin
              res_next            = res_zero;
              res_next.hit        = 1'b1;
              res_next.slot_index = SLOT_W'(idx);
              if (cur_act == ACT_BEACON) begin
                ram_we              = 1'b1;
                ram_wdata           = upd;
                res_next.miss_count = upd.miss;
                res_next.suspect    = upd.mark;
              end else begin
                res_next.miss_count = ram_rdata.miss;
                res_next.suspect    = ram_rdata.mark;
              end
              state_next = ST_EMIT;
            end else if (last) begin
              tail       = 1'b1;
              state_next = ST_EMIT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = idx_inc;
              idx_next  = idx_inc;
            end
          end
          default: begin
            res_next   = res_zero;
            state_next = ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Finish without a match: append a new beacon, drop it when full
    if (tail) begin
      res_next = res_zero;
      if (cur_act == ACT_BEACON) begin
        if (full) begin
          res_next.dropped_full = 1'b1;
        end else begin
          ram_we               = 1'b1;
          ram_waddr            = IDX_W'(count);
          ram_wdata.addr       = cur_addr;
          ram_wdata.miss       = '0;
          ram_wdata.mark       = 1'b0;
          count_next           = count_inc;
          res_next.slot_index  = SLOT_W'(count);
          res_next.entry_count = ECNT_W'(count_inc);
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Item and scan registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= act_t'(item.action);
      addr_q <= item.address;
    end
    idx <= idx_next;
    res <= res_next;
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res <= res;
    end
  end

  assign item.ready          = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.hit          = out_res.hit;
  assign result.slot_index   = out_res.slot_index;
  assign result.miss_count   = out_res.miss_count;
  assign result.suspect      = out_res.suspect;
  assign result.entry_count  = out_res.entry_count;
  assign result.dropped_full = out_res.dropped_full;

endmodule

// ===== sv/neighbor_liveness_table.sv =====
// Top level of the neighbour liveness table: configuration register, entry RAM and sequencer.
//
//   channel  | role   | payload
//   ---------+--------+---------------------------------------------------------------
//   item     | sink   | action, address
//   result   | source | hit, slot_index, miss_count, suspect, entry_count, dropped_full
//   APB      | slave  | retry_limit at byte address 0
//
// A beacon or lookup reads entries until the match (at most the entry count); a tick reads
// every entry below the count; an unused code or an empty table reads none. While scanning,
// the entry RAM read port yields one entry a cycle.
// Reset clears the entry count and the sequencer; the RAM is not cleared, as only entries
// below the count are read. A stalled result holds in the output register while the next
// transaction is accepted; the scan then waits in its final state until the register frees.
`include "neighbor_liveness_table_defines.svh"

module neighbor_liveness_table import nlt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  nlt_in_if.sink                item,
  nlt_out_if.source             result
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  logic [RL_W-1:0]  retry_limit;
  logic             reg_sel;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  // Register decode
  assign reg_sel = (paddr[2] == REG_RETRY_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(retry_limit) : '0;

  // Retry limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      retry_limit <= pwdata[RL_W-1:0];
    end
  end

  // Entry store
  nlt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan and update sequencer
  nlt_seq #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .retry_limit (retry_limit),
    .item        (item),
    .result      (result),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // Checks
  `NLT_ASSERT_NXT(a_busy_after_accept, item.valid && item.ready, !item.ready)
  `NLT_ASSERT_IMP(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
  `NLT_ASSERT_IMP(a_drop_clean, result.valid && result.dropped_full, !result.hit && result.slot_index == '0)

endmodule
